/* src/rotation_vector_to_quaternion_macros.svh */
// Assertion macros for the rotation vector to quaternion checker
`ifndef ROTATION_VECTOR_TO_QUATERNION_MACROS_SVH
`define ROTATION_VECTOR_TO_QUATERNION_MACROS_SVH

// clocked on clk, quiet while rst_n is low
`define RVQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rvq assertion failed");

// same-cycle implication
`define RVQ_ASSERT_IMP(lbl, ante, cons) \
  `RVQ_ASSERT(lbl, (ante) |-> (cons))

// next-cycle implication
`define RVQ_ASSERT_NXT(lbl, ante, cons) \
  `RVQ_ASSERT(lbl, (ante) |=> (cons))

`endif

/* src/rvq_pkg.sv */
// Constants, tables, types and helpers for the rotation vector to quaternion pipeline
package rvq_pkg;

  localparam int TRIG_ITER_DEF = 24;
  localparam int ATAN_N        = 31;

  localparam logic [31:0]        ONE_Q30     = 32'd1073741824;
  localparam logic [63:0]        PI_SQ_Q56   = 64'd2649351758 << 28;
  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [31:0] ATAN_Q30 [ATAN_N] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001
  };

  // constant dividers of the series path: reciprocal multiply plus one correction
  localparam int NDIV  = 5;
  localparam int DI_30 = 0;
  localparam int DI_12 = 1;
  localparam int DI_42 = 2;
  localparam int DI_20 = 3;
  localparam int DI_6  = 4;

  localparam logic [31:0] DIV_D [NDIV] = '{32'd30, 32'd12, 32'd42, 32'd20, 32'd6};
  localparam logic [31:0] DIV_H [NDIV] = '{32'd15, 32'd6, 32'd21, 32'd10, 32'd3};
  localparam int          DIV_K [NDIV] = '{36, 35, 37, 36, 34};
  localparam logic [31:0] DIV_M [NDIV] = '{
    32'((64'd1 << 36) / 64'd30), 32'((64'd1 << 35) / 64'd12), 32'((64'd1 << 37) / 64'd42),
    32'((64'd1 << 36) / 64'd20), 32'((64'd1 << 34) / 64'd6)
  };

  localparam logic [63:0] RND30 = 64'd1 << 29;
  localparam logic [63:0] RND29 = 64'd1 << 28;

  // side data travelling with each word
  typedef struct packed {
    logic [2:0][31:0]       r;
    logic                   big_angle;
    logic                   flip;
    logic [31:0]            m;
    logic signed [32:0]     ser_w;
    logic [2:0][33:0]       ser_v;
    logic [31:0]            cw;
    logic [2:0]             vneg;
  } side_t;

  function automatic logic [31:0] mag32(input logic [31:0] a);
    return a[31] ? (~a + 32'd1) : a;
  endfunction

  function automatic logic [31:0] sat34(input logic [33:0] a);
    return (a > 34'(ONE_Q30)) ? ONE_Q30 : a[31:0];
  endfunction

endpackage

/* src/rotation_vector_to_quaternion.sv */
// Rotation vector (Q3.28) to unit quaternion (Q1.30): top level pipeline
// Fully pipelined: one word accepted per cycle while the output is not stalled,
// and results leave in order.
// The depth is set by the 32-stage square root, one CORDIC stage per
// iteration and three 34-stage restoring dividers running side by side; the
// series path is computed alongside and delayed to match. The whole pipeline
// advances together and holds while a result waits on out_ready.
module rotation_vector_to_quaternion
  import rvq_pkg::*;
#(
  parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_rot_x,
  input  logic signed [31:0] in_rot_y,
  input  logic signed [31:0] in_rot_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_quat_w,
  output logic signed [31:0] out_quat_x,
  output logic signed [31:0] out_quat_y,
  output logic signed [31:0] out_quat_z,
  output logic               out_large_angle
);

  localparam int NI     = (TRIG_ITERATIONS < ATAN_N) ? TRIG_ITERATIONS : ATAN_N;
  localparam int ST_RT0 = 3;
  localparam int RT_N   = 32;
  localparam int ST_SER = 11;
  localparam int ST_RED = ST_RT0 + RT_N;
  localparam int ST_CR0 = ST_RED + 1;
  localparam int ST_MUL = ST_CR0 + NI;
  localparam int ST_REM = ST_MUL + 1;
  localparam int ST_DV0 = ST_REM + 1;
  localparam int DV_N   = 34;
  localparam int ST_OUT = ST_DV0 + DV_N;

  logic              en;
  logic [ST_OUT:0]   v_r;

  side_t side_r   [ST_OUT];
  side_t side_nxt [ST_OUT];

  logic [63:0] sq_r [3];
  logic [63:0] sq_nxt [3];
  logic [63:0] m2_r;
  logic [63:0] m2_nxt;

  logic [63:0] rt_v_r [RT_N];
  logic [63:0] rt_q_r [RT_N];
  logic [63:0] rt_v_in [RT_N];
  logic [63:0] rt_q_in [RT_N];
  logic [63:0] rt_v_nxt [RT_N];
  logic [63:0] rt_q_nxt [RT_N];
  logic [63:0] rt_trial [RT_N];

  // series path
  logic [31:0] t_r, t_nxt;
  logic [31:0] n_r [NDIV];
  logic [31:0] n_nxt [NDIV];
  logic [63:0] pm_r [NDIV];
  logic [63:0] pm_nxt [NDIV];
  logic [31:0] q0 [NDIV];
  logic [31:0] rem [NDIV];
  logic [31:0] q_r [NDIV];
  logic [31:0] q_nxt [NDIV];
  logic [31:0] t2_4_r, t2_5_r, t2_6_r, t2_7_r, t2_nxt;
  logic [31:0] q6_6_r, q6_7_r;
  logic [31:0] a1, b1;
  logic [63:0] pa_r, pb_r;
  logic [31:0] a2_r, b2_r;
  logic [63:0] pc_r, ps_r;
  logic signed [32:0] cs9_r, cs10_r, cs_nxt;
  logic [31:0] sn_r, sn_nxt;
  logic [63:0] pv_r [3];
  logic [63:0] pv_nxt [3];

  // angle reduction and CORDIC
  logic signed [35:0] ang, z1, red_z_nxt, red_z_r;
  logic               red_f;
  logic signed [33:0] cx_r [NI];
  logic signed [33:0] cy_r [NI];
  logic signed [35:0] cz_r [NI];
  logic signed [33:0] cx_in [NI];
  logic signed [33:0] cy_in [NI];
  logic signed [35:0] cz_in [NI];
  logic signed [33:0] cx_nxt [NI];
  logic signed [33:0] cy_nxt [NI];
  logic signed [35:0] cz_nxt [NI];

  // vector scaling and division
  logic signed [33:0] xl, yl;
  logic [31:0]        xmag, ymag;
  logic               xneg, yneg, cneg, sneg, fl;
  logic [63:0] pr_r [3];
  logic [63:0] pr_nxt [3];
  logic [63:0] rm_r [3];
  logic [63:0] rm_nxt [3];
  logic [63:0] dr_r [3][DV_N];
  logic [33:0] dq_r [3][DV_N];
  logic [63:0] dr_in [3][DV_N];
  logic [33:0] dq_in [3][DV_N];
  logic [63:0] dr_nxt [3][DV_N];
  logic [33:0] dq_nxt [3][DV_N];
  logic [65:0] dsh [3][DV_N];
  logic        dge [3][DV_N];

  // output stage
  side_t       sd;
  logic [31:0] w_nxt;
  logic [31:0] vm [3];
  logic        vn [3];
  logic [31:0] vo [3];
  logic signed [31:0] out_w_r, out_x_r, out_y_r, out_z_r;
  logic               out_l_r;

  assign en        = !v_r[ST_OUT] || out_ready;
  assign in_ready  = en;
  assign out_valid = v_r[ST_OUT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[ST_OUT-1:0], in_valid};
    end
  end

  // side data, squares and sum
  always_comb begin
    side_nxt[0]      = '0;
    side_nxt[0].r[0] = in_rot_x;
    side_nxt[0].r[1] = in_rot_y;
    side_nxt[0].r[2] = in_rot_z;
    for (int i = 1; i < ST_OUT; i++) begin
      side_nxt[i] = side_r[i-1];
    end
    for (int k = 0; k < 3; k++) begin
      sq_nxt[k] = 64'(mag32(side_r[0].r[k])) * 64'(mag32(side_r[0].r[k]));
    end
    m2_nxt = sq_r[0] + sq_r[1] + sq_r[2];
    side_nxt[ST_RT0].big_angle = (m2_r >= PI_SQ_Q56);
    side_nxt[ST_SER].ser_w = cs10_r;
    for (int k = 0; k < 3; k++) begin
      side_nxt[ST_SER].ser_v[k] = 34'((pv_r[k] + RND29) >> 29);
    end
    side_nxt[ST_RED].m    = rt_q_r[RT_N-1][31:0];
    side_nxt[ST_RED].flip = red_f;
    side_nxt[ST_MUL].cw   = xmag;
    for (int k = 0; k < 3; k++) begin
      side_nxt[ST_MUL].vneg[k] = side_r[ST_MUL-1].r[k][31] ^ sneg ^ cneg;
    end
  end

  // square root, one result bit per stage
  always_comb begin
    rt_v_in[0] = m2_r;
    rt_q_in[0] = '0;
    for (int k = 1; k < RT_N; k++) begin
      rt_v_in[k] = rt_v_r[k-1];
      rt_q_in[k] = rt_q_r[k-1];
    end
    for (int k = 0; k < RT_N; k++) begin
      rt_trial[k] = rt_q_in[k] + (64'd1 << (62 - 2*k));
      if (rt_v_in[k] >= rt_trial[k]) begin
        rt_v_nxt[k] = rt_v_in[k] - rt_trial[k];
        rt_q_nxt[k] = (rt_q_in[k] >> 1) + (64'd1 << (62 - 2*k));
      end else begin
        rt_v_nxt[k] = rt_v_in[k];
        rt_q_nxt[k] = rt_q_in[k] >> 1;
      end
    end
  end

  // series in the squared half-angle
  always_comb begin
    t_nxt  = 32'((m2_r + (64'd1 << 27)) >> 28);
    t2_nxt = 32'((33'(t_r) + 33'd1) >> 1);
    for (int d = 0; d < NDIV; d++) begin
      n_nxt[d]  = t_r + DIV_H[d];
      pm_nxt[d] = 64'(n_nxt[d]) * 64'(DIV_M[d]);
      q0[d]     = 32'(pm_r[d] >> DIV_K[d]);
      rem[d]    = n_r[d] - 32'(q0[d] * DIV_D[d]);
      q_nxt[d]  = (rem[d] >= DIV_D[d]) ? q0[d] + 32'd1 : q0[d];
    end
    a1     = ONE_Q30 - q_r[DI_30];
    b1     = ONE_Q30 - q_r[DI_42];
    cs_nxt = 33'(ONE_Q30) - 33'((pc_r + RND30) >> 30);
    sn_nxt = ONE_Q30 - 32'((ps_r + RND30) >> 30);
    for (int k = 0; k < 3; k++) begin
      pv_nxt[k] = 64'(mag32(side_r[ST_SER-2].r[k])) * 64'(sn_r);
    end
  end

  // half-angle range reduction
  always_comb begin
    ang = signed'({3'b000, rt_q_r[RT_N-1][31:0], 1'b0});
    z1  = (ang > PI_Q30) ? ang - TWO_PI_Q30 : ang;
    if (z1 > HALF_PI_Q30) begin
      red_z_nxt = z1 - PI_Q30;
      red_f     = 1'b1;
    end else if (z1 < -HALF_PI_Q30) begin
      red_z_nxt = z1 + PI_Q30;
      red_f     = 1'b1;
    end else begin
      red_z_nxt = z1;
      red_f     = 1'b0;
    end
  end

  // CORDIC, one iteration per stage
  always_comb begin
    cx_in[0] = CORDIC_GAIN;
    cy_in[0] = '0;
    cz_in[0] = red_z_r;
    for (int j = 1; j < NI; j++) begin
      cx_in[j] = cx_r[j-1];
      cy_in[j] = cy_r[j-1];
      cz_in[j] = cz_r[j-1];
    end
    for (int j = 0; j < NI; j++) begin
      if (cz_in[j] >= 0) begin
        cx_nxt[j] = cx_in[j] - (cy_in[j] >>> j);
        cy_nxt[j] = cy_in[j] + (cx_in[j] >>> j);
        cz_nxt[j] = cz_in[j] - signed'({4'b0000, ATAN_Q30[j]});
      end else begin
        cx_nxt[j] = cx_in[j] + (cy_in[j] >>> j);
        cy_nxt[j] = cy_in[j] - (cx_in[j] >>> j);
        cz_nxt[j] = cz_in[j] + signed'({4'b0000, ATAN_Q30[j]});
      end
    end
  end

  // signs, products and dividers
  always_comb begin
    xl   = cx_r[NI-1];
    yl   = cy_r[NI-1];
    fl   = side_r[ST_MUL-1].flip;
    xneg = xl < 0;
    yneg = yl < 0;
    xmag = 32'(xneg ? -xl : xl);
    ymag = 32'(yneg ? -yl : yl);
    cneg = fl ? (!xneg && (xl != 0)) : xneg;
    sneg = fl ? (!yneg && (yl != 0)) : yneg;
    for (int k = 0; k < 3; k++) begin
      pr_nxt[k] = 64'(mag32(side_r[ST_MUL-1].r[k])) * 64'(ymag);
      rm_nxt[k] = pr_r[k] + 64'(side_r[ST_REM-1].m >> 1);
      dr_in[k][0] = rm_r[k];
      dq_in[k][0] = '0;
      for (int j = 1; j < DV_N; j++) begin
        dr_in[k][j] = dr_r[k][j-1];
        dq_in[k][j] = dq_r[k][j-1];
      end
      for (int j = 0; j < DV_N; j++) begin
        dsh[k][j]    = 66'(side_r[ST_DV0-1+j].m) << (DV_N - 1 - j);
        dge[k][j]    = ({2'b00, dr_in[k][j]} >= dsh[k][j]);
        dr_nxt[k][j] = dge[k][j] ? dr_in[k][j] - dsh[k][j][63:0] : dr_in[k][j];
        dq_nxt[k][j] = {dq_in[k][j][32:0], dge[k][j]};
      end
    end
  end

  // path select and saturation
  always_comb begin
    sd = side_r[ST_OUT-1];
    if (sd.big_angle) begin
      w_nxt = sat34(34'(sd.cw));
    end else if (sd.ser_w > 33'sd1073741824) begin
      w_nxt = ONE_Q30;
    end else if (sd.ser_w < -33'sd1073741824) begin
      w_nxt = ~ONE_Q30 + 32'd1;
    end else begin
      w_nxt = sd.ser_w[31:0];
    end
    for (int k = 0; k < 3; k++) begin
      if (sd.big_angle) begin
        vm[k] = sat34(dq_r[k][DV_N-1]);
        vn[k] = sd.vneg[k];
      end else begin
        vm[k] = sat34(sd.ser_v[k]);
        vn[k] = sd.r[k][31];
      end
      vo[k] = vn[k] ? (~vm[k] + 32'd1) : vm[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r  <= side_nxt;
      sq_r    <= sq_nxt;
      m2_r    <= m2_nxt;
      rt_v_r  <= rt_v_nxt;
      rt_q_r  <= rt_q_nxt;
      t_r     <= t_nxt;
      n_r     <= n_nxt;
      pm_r    <= pm_nxt;
      t2_4_r  <= t2_nxt;
      q_r     <= q_nxt;
      t2_5_r  <= t2_4_r;
      pa_r    <= 64'(q_r[DI_12]) * 64'(a1);
      pb_r    <= 64'(q_r[DI_20]) * 64'(b1);
      q6_6_r  <= q_r[DI_6];
      t2_6_r  <= t2_5_r;
      a2_r    <= ONE_Q30 - 32'((pa_r + RND30) >> 30);
      b2_r    <= ONE_Q30 - 32'((pb_r + RND30) >> 30);
      q6_7_r  <= q6_6_r;
      t2_7_r  <= t2_6_r;
      pc_r    <= 64'(t2_7_r) * 64'(a2_r);
      ps_r    <= 64'(q6_7_r) * 64'(b2_r);
      cs9_r   <= cs_nxt;
      sn_r    <= sn_nxt;
      cs10_r  <= cs9_r;
      pv_r    <= pv_nxt;
      red_z_r <= red_z_nxt;
      cx_r    <= cx_nxt;
      cy_r    <= cy_nxt;
      cz_r    <= cz_nxt;
      pr_r    <= pr_nxt;
      rm_r    <= rm_nxt;
      dr_r    <= dr_nxt;
      dq_r    <= dq_nxt;
      out_w_r <= w_nxt;
      out_x_r <= vo[0];
      out_y_r <= vo[1];
      out_z_r <= vo[2];
      out_l_r <= sd.big_angle;
    end
  end

  assign out_quat_w      = out_w_r;
  assign out_quat_x      = out_x_r;
  assign out_quat_y      = out_y_r;
  assign out_quat_z      = out_z_r;
  assign out_large_angle = out_l_r;

endmodule

/* src/rvq_chk.sv */
// Port-level checker for the rotation vector to quaternion block, with its bind
`include "rotation_vector_to_quaternion_macros.svh"

module rvq_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_quat_w,
  input logic               out_large_angle
);

  `RVQ_ASSERT_IMP(a_no_stall, !out_valid || out_ready, in_ready)
  `RVQ_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_quat_w))
  `RVQ_ASSERT_IMP(a_w_range, out_valid, (out_quat_w <= 32'sd1073741824) && (out_quat_w >= -32'sd1073741824))
  `RVQ_ASSERT_IMP(a_large_w_pos, out_valid && out_large_angle, !out_quat_w[31])

endmodule

bind rotation_vector_to_quaternion rvq_chk u_rvq_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_quat_w      (out_quat_w),
  .out_large_angle (out_large_angle)
);

/* sim/rotation_vector_to_quaternion_test.sv */
// Self-checking testbench: rotation vector to quaternion pipeline against its own predictor
module rotation_vector_to_quaternion_test
  import rvq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CORDIC_STEPS = (TRIG_ITER_DEF < ATAN_N) ? TRIG_ITER_DEF : ATAN_N;
  localparam int N_RANDOM     = 1800;
  localparam logic signed [31:0] PI_Q28     = 32'sd843314856;
  localparam logic signed [31:0] TWO_PI_Q28 = 32'sd1686629713;
  localparam logic signed [31:0] S32_MAX    = 32'sh7FFFFFFF;
  localparam logic signed [31:0] S32_MIN    = 32'sh80000000;

  typedef struct {
    logic signed [31:0] x, y, z;
    bit                 drain;
  } vec_t;

  typedef struct {
    logic signed [31:0] w, x, y, z;
    logic               big_angle;
  } quat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_rot_x = '0, in_rot_y = '0, in_rot_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_quat_w, out_quat_x, out_quat_y, out_quat_z;
  logic out_large_angle;

  vec_t  pending_q[$];
  quat_t quat_q[$];
  int    errors = 0;
  int    accepted = 0;
  int    cycle = 0;
  int    send_gap = 0;
  int    recv_wait = 0;
  int    long_hold = 0;
  bit    long_hold_done = 1'b0;
  bit    in_fire = 1'b0;
  bit    calm;

  rotation_vector_to_quaternion dut (.*);

  always #6 clk = ~clk;

  function automatic bit [63:0] div_round(input bit [63:0] a, input bit [63:0] d);
    return (d == 0) ? 64'd0 : (a + d / 2) / d;
  endfunction

  function automatic bit [63:0] mul_round(input bit [63:0] a, input bit [63:0] b,
                                          input int s);
    return (a * b + (64'd1 << (s - 1))) >> s;
  endfunction

  function automatic logic [31:0] clamp_q30(input longint v);
    if (v > longint'(ONE_Q30)) v = longint'(ONE_Q30);
    if (v < -longint'(ONE_Q30)) v = -longint'(ONE_Q30);
    return v[31:0];
  endfunction

  function automatic longint with_sign(input bit [63:0] m, input bit neg);
    longint v;
    v = longint'(m & 64'h3FFFFFFFFFFFFFFF);
    return neg ? -v : v;
  endfunction

  function automatic bit [63:0] int_sqrt(input bit [63:0] v);
    bit [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic quat_t quat_of(input vec_t v);
    longint    r[3];
    bit [63:0] mag[3];
    bit [63:0] msq, t, a1, a2, b1, b2, sn, m, q;
    longint    cs, x, y, z, nx;
    bit        flip, neg;
    quat_t     res;
    logic [31:0] part[3];
    r[0] = v.x;
    r[1] = v.y;
    r[2] = v.z;
    msq = 0;
    for (int k = 0; k < 3; k++) begin
      mag[k] = (r[k] < 0) ? -r[k] : r[k];
      msq += r[k] * r[k];
    end
    if (msq < PI_SQ_Q56) begin
      t  = (msq + (64'd1 << 27)) >> 28;
      a1 = ONE_Q30 - div_round(t, 30);
      a2 = ONE_Q30 - mul_round(div_round(t, 12), a1, 30);
      cs = longint'(ONE_Q30) - longint'(mul_round(div_round(t, 2), a2, 30));
      b1 = ONE_Q30 - div_round(t, 42);
      b2 = ONE_Q30 - mul_round(div_round(t, 20), b1, 30);
      sn = ONE_Q30 - mul_round(div_round(t, 6), b2, 30);
      res.w = clamp_q30(cs);
      for (int k = 0; k < 3; k++)
        part[k] = clamp_q30(with_sign(mul_round(mag[k], sn, 29), r[k] < 0));
      res.big_angle = 1'b0;
    end else begin
      m = int_sqrt(msq);
      x = CORDIC_GAIN;
      y = 0;
      z = longint'(m * 2);
      flip = 1'b0;
      if (z > PI_Q30) z -= TWO_PI_Q30;
      if (z > HALF_PI_Q30) begin
        z -= PI_Q30;
        flip = 1'b1;
      end else if (z < -HALF_PI_Q30) begin
        z += PI_Q30;
        flip = 1'b1;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          z -= longint'(ATAN_Q30[i]);
        end else begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          z += longint'(ATAN_Q30[i]);
        end
        x = nx;
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      neg = x < 0;
      res.w = clamp_q30(neg ? -x : x);
      for (int k = 0; k < 3; k++) begin
        q = div_round(mag[k] * ((y < 0) ? -y : y), m);
        part[k] = clamp_q30(with_sign(q, ((r[k] < 0) != (y < 0)) != neg));
      end
      res.big_angle = 1'b1;
    end
    res.x = part[0];
    res.y = part[1];
    res.z = part[2];
    return res;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic logic signed [31:0] rnd_comp(input int kind);
    case (kind)
      0: return $urandom;
      1: return $signed($urandom) >>> $urandom_range(1, 14);
      default: return $signed($urandom) >>> 3;
    endcase
  endfunction

  assign calm = ((cycle / 400) % 4) == 1;

  always @(posedge clk) begin
    cycle <= cycle + 1;
    in_fire = rst_n && in_valid && in_ready;
    if (in_fire) begin
      quat_q.push_back(quat_of('{in_rot_x, in_rot_y, in_rot_z, 1'b0}));
      accepted <= accepted + 1;
      if (accepted == 700 && !long_hold_done) begin
        long_hold <= 400;
        long_hold_done <= 1'b1;
      end
    end
    if (rst_n && out_valid && out_ready) begin
      recv_wait <= draw_wait();
      if (quat_q.size() == 0) begin
        report("unexpected word", out_quat_w, '0);
      end else begin
        quat_t e;
        e = quat_q.pop_front();
        if (out_quat_w !== e.w) report("quat_w", out_quat_w, e.w);
        if (out_quat_x !== e.x) report("quat_x", out_quat_x, e.x);
        if (out_quat_y !== e.y) report("quat_y", out_quat_y, e.y);
        if (out_quat_z !== e.z) report("quat_z", out_quat_z, e.z);
        if (out_large_angle !== e.big_angle)
          report("large_angle", out_large_angle, e.big_angle);
      end
    end
  end

  // sender
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_fire)) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_q.size() > 0 &&
                   !(pending_q[0].drain && (quat_q.size() > 0 || in_valid))) begin
        vec_t v;
        v = pending_q.pop_front();
        in_rot_x <= v.x;
        in_rot_y <= v.y;
        in_rot_z <= v.z;
        in_valid <= 1'b1;
        send_gap <= draw_wait();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (long_hold > 0) begin
      out_ready <= 1'b0;
      long_hold <= long_hold - 1;
    end else if (recv_wait > 0) begin
      out_ready <= 1'b0;
      recv_wait <= recv_wait - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    vec_t v;
    vec_t directed[$];
    directed = '{
      '{0, 0, 0, 0}, '{1, -1, 1, 0}, '{S32_MAX, S32_MAX, S32_MAX, 0},
      '{S32_MIN, S32_MIN, S32_MIN, 0}, '{S32_MIN, 0, 0, 0}, '{S32_MAX, 0, 0, 0},
      '{0, S32_MIN, 0, 0}, '{0, 0, S32_MAX, 0}, '{PI_Q28, 0, 0, 0},
      '{PI_Q28 + 1, 0, 0, 0}, '{0, -PI_Q28, 0, 0}, '{0, 0, -PI_Q28 - 1, 0},
      '{TWO_PI_Q28, 0, 0, 0}, '{0, -TWO_PI_Q28, 0, 0}, '{PI_Q28 + 5000000, 0, 0, 0},
      '{300000000, -400000000, 500000000, 0}, '{-600000000, 500000000, 400000000, 0},
      '{S32_MIN, S32_MAX, 0, 0}, '{-1, -1, -1, 0}, '{800000000, 100000, -1, 0}
    };
    foreach (directed[i]) pending_q.push_back(directed[i]);
    for (int n = 0; n < N_RANDOM; n++) begin
      int kind;
      kind = $urandom_range(0, 2);
      v.x = rnd_comp(kind);
      v.y = rnd_comp(kind);
      v.z = rnd_comp(kind);
      v.drain = (n == 1200);
      pending_q.push_back(v);
    end
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    wait (pending_q.size() == 0);
    @(negedge clk);
    wait (!in_valid && quat_q.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #10ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
